// ===== sv/text_justifier_core_defines.svh =====
// Assertion macros shared by the text justifier checker.
// Depends on nothing; expects i_clk and i_rst_n in the using scope.
`ifndef TEXT_JUSTIFIER_CORE_DEFINES_SVH
`define TEXT_JUSTIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define JT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define JT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jt_pkg.sv =====
// Shared types, constants and helpers of the text justifier.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package jt_pkg;
    localparam int MAX_WIDTH   = 32;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int DIV_STEPS   = 6;

    localparam logic [7:0]       SPACE_CHAR     = 8'h20;
    localparam logic [CNT_W-1:0] RESET_WIDTH    = 6'd16;
    localparam logic [1:0]       ADDR_MAX_WIDTH = 2'd0;

    typedef struct packed {
        logic [7:0] character;
        logic       word_end;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       line_end;
        logic       run_last;
    } t_out_item;

    // Classified character as passed from front to back
    typedef struct packed {
        logic [7:0]       character;
        logic             word_end;
        logic             text_end;
        logic             store;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] word_len;
    } t_qent;

    // Clamp the programmed width into 1..MAX_WIDTH
    function automatic logic [CNT_W-1:0] eff_width(input logic [CNT_W-1:0] mw);
        logic [CNT_W-1:0] res;
        if (mw == '0) begin
            res = CNT_W'(1);
        end else if (mw > CNT_W'(MAX_WIDTH)) begin
            res = CNT_W'(MAX_WIDTH);
        end else begin
            res = mw;
        end
        return res;
    endfunction
endpackage

// ===== sv/jt_front.sv =====
// Front end: accepts characters, tracks word length, classifies for the back end.
// Depends on jt_pkg.
`timescale 1ns / 1ps
module jt_front import jt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_item,
    input  logic [CNT_W-1:0] i_width,
    input  logic             i_full,
    output logic             o_push,
    output t_qent            o_qent
);
    logic [CNT_W-1:0] r_wc;
    logic [CNT_W-1:0] n_wc;
    logic             store;
    logic [CNT_W-1:0] wc_after;

    assign o_ready  = !i_full;
    assign o_push   = i_valid && !i_full;
    // Keep a byte only while the word still fits the width
    assign store    = (r_wc < i_width);
    assign wc_after = store ? r_wc + CNT_W'(1) : r_wc;

    always_comb begin
        o_qent.character = i_item.character;
        o_qent.word_end  = i_item.word_end;
        o_qent.text_end  = i_item.text_end;
        o_qent.store     = store;
        o_qent.idx       = r_wc[IDX_W-1:0];
        o_qent.word_len  = wc_after;
    end

    // Advance the word count, restart it at each word or text end
    always_comb begin
        n_wc = r_wc;
        if (o_push) begin
            if (i_item.word_end || i_item.text_end) begin
                n_wc = '0;
            end else begin
                n_wc = wc_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= '0;
        end else begin
            r_wc <= n_wc;
        end
    end
endmodule

// ===== sv/jt_fifo.sv =====
// Short queue between front and back end.
// Depends on jt_pkg.
`timescale 1ns / 1ps
module jt_fifo import jt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_qent o_data
);
    t_qent             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end
endmodule

// ===== sv/jt_back.sv =====
// Back end: builds the held line, divides spare spaces, emits columns.
// Depends on jt_pkg.
`timescale 1ns / 1ps
module jt_back import jt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_qvalid,
    input  t_qent            i_qent,
    output logic             o_pop,
    input  logic [CNT_W-1:0] i_width,
    output logic             o_out_valid,
    output t_out_item        o_out_data,
    input  logic             i_out_ready
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_EMIT = 3'd2;
    localparam logic [2:0] S_GAP  = 3'd3;
    localparam logic [2:0] S_COPY = 3'd4;

    logic [7:0]           r_line [MAX_WIDTH];
    logic [7:0]           r_word [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] r_mark;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_lc, n_lc;
    logic [CNT_W-1:0] r_lw, n_lw;
    logic [CNT_W-1:0] r_wc, n_wc;
    logic             r_tend, n_tend;
    logic             r_just, n_just;
    logic [CNT_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_sp, n_sp;
    logic [CNT_W-1:0] r_gi, n_gi;
    logic [CNT_W-1:0] r_gaps, n_gaps;
    logic [CNT_W-1:0] r_base, n_base;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_extra, n_extra;
    logic [2:0]       r_dcnt, n_dcnt;
    logic             r_ov, n_ov;
    t_out_item        r_od, n_od;

    logic             line_we;
    logic [7:0]       line_wd;
    logic             mark_wd;
    logic             word_we;
    logic             overflow;
    logic [CNT_W-1:0] extra_now;
    logic [CNT_W-1:0] gaps_now;
    logic [CNT_W-1:0] share;
    logic [CNT_W:0]   trial;
    logic             last_col;
    logic [7:0]       ch;

    assign o_pop       = (r_state == S_IDLE) && i_qvalid;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    // Fit check of the finished word against the held line
    assign overflow  = (r_lw != '0) &&
                       (({1'b0, r_lc} + (CNT_W+1)'(1) + {1'b0, i_qent.word_len}) >
                        {1'b0, i_width});
    assign extra_now = (r_lc < i_width) ? i_width - r_lc : '0;
    assign gaps_now  = (r_lw > CNT_W'(1)) ? r_lw - CNT_W'(1) : '0;
    assign share     = (r_just && (r_gi < r_gaps)) ?
                       ((r_gi < r_rem) ? r_base + CNT_W'(1) : r_base) : '0;
    assign trial     = {r_rem, r_extra[r_dcnt]};
    assign last_col  = ({1'b0, r_col} == i_width - CNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_lc    = r_lc;
        n_lw    = r_lw;
        n_wc    = r_wc;
        n_tend  = r_tend;
        n_just  = r_just;
        n_i     = r_i;
        n_col   = r_col;
        n_sp    = r_sp;
        n_gi    = r_gi;
        n_gaps  = r_gaps;
        n_base  = r_base;
        n_rem   = r_rem;
        n_extra = r_extra;
        n_dcnt  = r_dcnt;
        n_ov    = r_ov;
        n_od    = r_od;
        line_we = 1'b0;
        line_wd = SPACE_CHAR;
        mark_wd = 1'b0;
        word_we = 1'b0;
        ch      = SPACE_CHAR;
        // Drop the output once taken
        if (i_out_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_qvalid) begin
                    word_we = i_qent.store;
                    n_wc    = i_qent.word_len;
                    n_tend  = i_qent.text_end;
                    if (i_qent.word_end || i_qent.text_end) begin
                        if (overflow) begin
                            n_just  = 1'b1;
                            n_extra = extra_now;
                            n_gaps  = gaps_now;
                            n_rem   = '0;
                            n_base  = '0;
                            n_dcnt  = 3'(DIV_STEPS - 1);
                            n_i     = '0;
                            n_col   = '0;
                            n_sp    = '0;
                            n_gi    = '0;
                            n_state = (gaps_now != '0) ? S_DIV : S_EMIT;
                        end else begin
                            n_state = S_GAP;
                        end
                    end
                end
            end
            S_DIV: begin
                // One quotient bit per cycle
                if (trial >= {1'b0, r_gaps}) begin
                    n_rem          = CNT_W'(trial - {1'b0, r_gaps});
                    n_base[r_dcnt] = 1'b1;
                end else begin
                    n_rem = CNT_W'(trial);
                end
                if (r_dcnt == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_dcnt = r_dcnt - 3'd1;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    if (r_sp != '0) begin
                        n_sp = r_sp - CNT_W'(1);
                    end else if (r_i < r_lc) begin
                        n_i = r_i + CNT_W'(1);
                        if (r_mark[r_i[IDX_W-1:0]]) begin
                            n_sp = share;
                            n_gi = r_gi + CNT_W'(1);
                        end else begin
                            ch = r_line[r_i[IDX_W-1:0]];
                        end
                    end
                    n_ov = 1'b1;
                    n_od = '{out_char: ch, line_end: last_col,
                             run_last: last_col && (!r_just || !r_tend)};
                    if (last_col) begin
                        n_col   = '0;
                        n_lc    = '0;
                        n_lw    = '0;
                        n_state = r_just ? S_GAP : S_IDLE;
                    end else begin
                        n_col = r_col + IDX_W'(1);
                    end
                end
            end
            S_GAP: begin
                // Insert the single gap ahead of a following word
                if ((r_lw != '0) && (r_lc < CNT_W'(MAX_WIDTH))) begin
                    line_we = 1'b1;
                    mark_wd = 1'b1;
                    n_lc    = r_lc + CNT_W'(1);
                end
                n_i     = '0;
                n_state = S_COPY;
            end
            S_COPY: begin
                if ((r_i < r_wc) && (r_lc < CNT_W'(MAX_WIDTH))) begin
                    line_we = 1'b1;
                    line_wd = r_word[r_i[IDX_W-1:0]];
                    n_lc    = r_lc + CNT_W'(1);
                    n_i     = r_i + CNT_W'(1);
                end else begin
                    n_lw = r_lw + CNT_W'(1);
                    if (r_tend) begin
                        n_just  = 1'b0;
                        n_i     = '0;
                        n_col   = '0;
                        n_sp    = '0;
                        n_gi    = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Line and word stores
    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line[r_lc[IDX_W-1:0]] <= line_wd;
            r_mark[r_lc[IDX_W-1:0]] <= mark_wd;
        end
        if (word_we) begin
            r_word[i_qent.idx] <= i_qent.character;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_wc    <= n_wc;
        r_tend  <= n_tend;
        r_just  <= n_just;
        r_i     <= n_i;
        r_col   <= n_col;
        r_sp    <= n_sp;
        r_gi    <= n_gi;
        r_gaps  <= n_gaps;
        r_base  <= n_base;
        r_rem   <= n_rem;
        r_extra <= n_extra;
        r_dcnt  <= n_dcnt;
        r_od    <= n_od;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lc    <= '0;
            r_lw    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lc    <= n_lc;
            r_lw    <= n_lw;
            r_ov    <= n_ov;
        end
    end
endmodule

// ===== sv/text_justifier_core.sv =====
// Top level of the greedy text justifier: config register, front, queue, back.
// Depends on jt_pkg, jt_front, jt_fifo, jt_back.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   i_in_data  (t_in_item)
//  output    out        o_out_valid / i_out_ready o_out_data (t_out_item)
//  config    in         psel, penable, pwrite     paddr, pwdata, prdata
//
// A character inside a word is taken in the back end's idle state; a word end
// then passes the gap and copy states to copy the word into the line store.
// A line is emitted column by column over the width, after the divider when
// it is justified over one or more gaps; the output register sets the pace.
// A four-entry queue lets the front keep taking characters while a line drains.
// Reset is synchronous and active low; the width register resets to 16.
`timescale 1ns / 1ps
module text_justifier_core import jt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [CNT_W-1:0] r_max_width;
    logic [CNT_W-1:0] width;
    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_qent            q_in;
    t_qent            q_out;

    assign pready = 1'b1;
    assign width  = eff_width(r_max_width);
    assign prdata = (paddr == ADDR_MAX_WIDTH) ? {{(32-CNT_W){1'b0}}, r_max_width} : '0;

    // Width register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width <= RESET_WIDTH;
        end else if (psel && penable && pwrite && (paddr == ADDR_MAX_WIDTH)) begin
            r_max_width <= pwdata[CNT_W-1:0];
        end
    end

    jt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .i_width (width),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_qent  (q_in)
    );

    jt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    jt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qvalid    (q_valid),
        .i_qent      (q_out),
        .o_pop       (q_pop),
        .i_width     (width),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );
endmodule

// ===== sv/jt_checker.sv =====
// Port-level checker of the text justifier, bound to the top level.
// Depends on jt_pkg and text_justifier_core_defines.svh.
`timescale 1ns / 1ps
`include "text_justifier_core_defines.svh"
module jt_checker import jt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_data,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [1:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    // Hold a stalled output transaction
    `JT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "output changed while stalled")
    // The last column of a run closes a line
    `JT_ASSERT_IMPL(a_run_last_line, o_out_valid && o_out_data.run_last, o_out_data.line_end, "run end off a line end")
    // A width write reads back
    `JT_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && (paddr == ADDR_MAX_WIDTH), prdata[5:0] == $past(pwdata[5:0]), "width register readback mismatch")
endmodule

bind text_justifier_core jt_checker u_jt_checker (.*);

// ===== test/text_justifier_core_test.sv =====
// Self-checking testbench of the greedy text justifier core.
// Depends on jt_pkg and text_justifier_core; predicts every output column locally.
`timescale 1ns / 1ps
module text_justifier_core_test;
    import jt_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    text_justifier_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state
    logic [7:0]  pr_line [MAX_WIDTH];
    logic        pr_gap [MAX_WIDTH];
    logic [7:0]  pr_word [MAX_WIDTH];
    int          pr_line_chars;
    int          pr_line_words;
    int          pr_word_chars;
    logic [5:0]  pr_width;

    t_in_item    pending_chars[$];
    t_out_item   expected_cols[$];
    int          mismatches;
    int          idle_pct;
    bit          hold_off_req;
    int          hold_off_left;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int width_now();
        if (pr_width == 6'd0) return 1;
        if (pr_width > 6'd32) return MAX_WIDTH;
        return int'(pr_width);
    endfunction

    function automatic void put_column(ref int col, input int w, input logic [7:0] c);
        t_out_item o;
        if (col >= w) return;
        o.out_char = c;
        o.line_end = (col == w - 1);
        o.run_last = 1'b0;
        expected_cols = {expected_cols, o};
        col++;
    endfunction

    // Emit the held line, justified or left-aligned
    function automatic void flush_line(input bit justify);
        int w;
        int extra;
        int gaps;
        int col;
        int share;
        w = width_now();
        extra = (pr_line_chars < w) ? w - pr_line_chars : 0;
        gaps = (pr_line_words > 1) ? pr_line_words - 1 : 0;
        col = 0;
        for (int i = 0; i < pr_line_chars && i < MAX_WIDTH; i++) begin
            if (pr_gap[i]) begin
                share = 0;
                if (justify && gaps > 0) begin
                    share = (extra + gaps - 1) / gaps;
                    gaps--;
                    extra -= share;
                end
                for (int k = 0; k <= share; k++) put_column(col, w, SPACE_CHAR);
            end else begin
                put_column(col, w, pr_line[i]);
            end
        end
        while (col < w) put_column(col, w, SPACE_CHAR);
        pr_line_chars = 0;
        pr_line_words = 0;
    endfunction

    function automatic void predict_char(input t_in_item it);
        int w;
        int before_n;
        t_out_item o;
        w = width_now();
        before_n = expected_cols.size();
        if (pr_word_chars < w) begin
            pr_word[pr_word_chars] = it.character;
            pr_word_chars++;
        end
        if (it.word_end || it.text_end) begin
            if (pr_line_words > 0 && pr_line_chars + 1 + pr_word_chars > w)
                flush_line(1'b1);
            if (pr_line_words > 0 && pr_line_chars < MAX_WIDTH) begin
                pr_line[pr_line_chars] = SPACE_CHAR;
                pr_gap[pr_line_chars] = 1'b1;
                pr_line_chars++;
            end
            for (int i = 0; i < pr_word_chars && pr_line_chars < MAX_WIDTH; i++) begin
                pr_line[pr_line_chars] = pr_word[i];
                pr_gap[pr_line_chars] = 1'b0;
                pr_line_chars++;
            end
            pr_line_words++;
            pr_word_chars = 0;
        end
        if (it.text_end) flush_line(1'b0);
        if (expected_cols.size() > before_n) begin
            o = expected_cols[$];
            o.run_last = 1'b1;
            expected_cols[$] = o;
        end
    endfunction

    // Driver: offer the oldest pending character, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_char(i_in_data);
                void'(pending_chars.pop_front());
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the offered transaction
            end else if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_chars[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted column, stall the output at random
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_off_left <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_cols.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected column %h/%b/%b", o_out_data.out_char,
                                 o_out_data.line_end, o_out_data.run_last);
                end else begin
                    want = expected_cols.pop_front();
                    if (want !== o_out_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("column mismatch: expected %h/%b/%b got %h/%b/%b",
                                     want.out_char, want.line_end, want.run_last,
                                     o_out_data.out_char, o_out_data.line_end,
                                     o_out_data.run_last);
                    end
                end
            end
            if (hold_off_req && hold_off_left == 0) begin
                hold_off_left <= 400;
                i_out_ready <= 1'b0;
            end else if (hold_off_left > 1) begin
                hold_off_left <= hold_off_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                hold_off_left <= 0;
                i_out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Watchdog on cycles with no transaction on the input, output or config port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic write_width(input logic [5:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_MAX_WIDTH; pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pr_width = value;
    endtask

    // Wait until every character is taken and every column has come back
    task automatic drain();
        while (pending_chars.size() != 0 || i_in_valid || expected_cols.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic queue_word(input int len, input bit last);
        t_in_item it;
        for (int i = 0; i < len; i++) begin
            it.character = 8'($urandom_range(255));
            if ($urandom_range(3) != 0) it.character = 8'($urandom_range(8'h7a, 8'h61));
            it.word_end = (i == len - 1);
            it.text_end = last && (i == len - 1);
            pending_chars = {pending_chars, it};
        end
    endtask

    task automatic queue_text(input int words, input int max_len);
        for (int i = 0; i < words; i++)
            queue_word($urandom_range(max_len, 1), i == words - 1);
    endtask

    initial begin
        t_in_item it;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; idle_pct = 18; hold_off_req = 1'b0;
        pr_line_chars = 0; pr_line_words = 0; pr_word_chars = 0;
        pr_width = RESET_WIDTH;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset width, extreme bytes, space byte, long word, two lines at once
        it = '{character: 8'h00, word_end: 1'b0, text_end: 1'b0};
        pending_chars = {pending_chars, it};
        it = '{character: 8'hff, word_end: 1'b1, text_end: 1'b0};
        pending_chars = {pending_chars, it};
        it = '{character: SPACE_CHAR, word_end: 1'b1, text_end: 1'b0};
        pending_chars = {pending_chars, it};
        queue_word(18, 1'b0);
        queue_word(3, 1'b0);
        queue_word(13, 1'b1);
        drain();

        // Width changed mid-text: held line emitted at the narrower width
        queue_word(4, 1'b0); queue_word(3, 1'b0);
        drain();
        write_width(6'd4);
        queue_word(1, 1'b1);
        drain();

        // Width zero acts as one; single text-end character
        write_width(6'd0);
        queue_word(3, 1'b0); queue_word(1, 1'b1);
        drain();

        // An out-of-range width and full width with many gaps
        write_width(6'd63);
        queue_text(4, 3);
        drain();
        write_width(6'd32);
        hold_off_req = 1'b1;
        for (int i = 0; i < 8; i++) queue_word(4, i == 7);
        wait (hold_off_left != 0);
        hold_off_req = 1'b0;
        drain();

        // Random texts over several widths, one stretch without idling
        for (int ph = 0; ph < 2; ph++) begin
            write_width(ph == 0 ? 6'd1 : 6'($urandom_range(32, 2)));
            idle_pct = (ph == 1) ? 0 : 18;
            queue_text($urandom_range(4, 2), $urandom_range(5, 1));
            drain();
        end
        idle_pct = 18;
        write_width(6'd37);
        queue_text(2, 3);
        drain();

        if (mismatches == 0 && expected_cols.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/jt_pkg.sv
sv/jt_front.sv
sv/jt_fifo.sv
sv/jt_back.sv
sv/text_justifier_core.sv
sv/jt_checker.sv
test/text_justifier_core_test.sv
